// ===== design/mlspi_pkg.sv =====
// ---------------------------------------------------------------------------
// mlspi_pkg
// Shared types and constants of the multi-lane SPI write master.
// ---------------------------------------------------------------------------
package mlspi_pkg;

    localparam int LANES    = 6;
    localparam int MSG_W    = 64;
    localparam int INS_W    = 8;
    localparam int OP_W     = 2;
    localparam int DELAY_W  = 16;
    localparam int GAP_DELAYS = 3;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(1);

    localparam int LONG_BITS_DEF        = 64;
    localparam int SHORT_BITS_DEF       = 32;
    localparam int INSTRUCTION_BITS_DEF = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_START    = 2'd1,
        OP_IO_RESET = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SETUP    = 4'd1,
        PH_INS_LOW  = 4'd2,
        PH_INS_HIGH = 4'd3,
        PH_GAP      = 4'd4,
        PH_MSG_LOW  = 4'd5,
        PH_MSG_HIGH = 4'd6,
        PH_TAIL     = 4'd7,
        PH_RST_LOW  = 4'd8,
        PH_RST_HIGH = 4'd9
    } t_phase;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [INS_W-1:0] instruction;
        logic [LANES-1:0] channel_mask;
        logic             extended;
        logic [MSG_W-1:0] lane0_message;
        logic [MSG_W-1:0] lane1_message;
        logic [MSG_W-1:0] lane2_message;
        logic [MSG_W-1:0] lane3_message;
        logic [MSG_W-1:0] lane4_message;
        logic [MSG_W-1:0] lane5_message;
    } t_in_word;

    typedef struct packed {
        logic             serial_clock;
        logic [LANES-1:0] chip_select_n;
        logic [LANES-1:0] serial_data;
        logic             io_reset;
        logic             busy_res;
        logic             done_res;
    } t_out_word;

endpackage

// ===== design/multi_lane_spi_write_master.sv =====
// ---------------------------------------------------------------------------
// multi_lane_spi_write_master
// Six-lane write-only SPI master with one shared serial clock.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_word) carries one command
// word: a tick, a start of a write, or an IO reset strobe. The output
// channel (o_out_valid / i_out_stall / o_out_word) returns exactly one word
// per command: the pin levels after that command plus busy and done flags.
// i_cfg_we / i_cfg_data set the delay length in ticks; write it only while
// no sequence runs.
// Throughput is one word per cycle while i_out_stall is low. A word passes
// an input register, then the pin sequencer update, captured in the result register.
// Pin timing is counted in tick words, not clocks: each pin change waits
// delay_ticks ticks (zero counts as one).
// Reset clears the sequencer to idle (chip selects high, clock, data and IO
// reset low), empties both registers and sets the delay to one tick.
// While i_out_stall is high a pending result holds; the input register still
// takes one word, then o_in_stall rises until the result drains.
// ---------------------------------------------------------------------------
module multi_lane_spi_write_master #(
    parameter int LONG_BITS        = mlspi_pkg::LONG_BITS_DEF,
    parameter int SHORT_BITS       = mlspi_pkg::SHORT_BITS_DEF,
    parameter int INSTRUCTION_BITS = mlspi_pkg::INSTRUCTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mlspi_pkg::t_in_word           i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mlspi_pkg::t_out_word          o_out_word,
    input  logic                          i_cfg_we,
    input  logic [mlspi_pkg::DELAY_W-1:0] i_cfg_data
);

    logic                           r_in_valid;
    mlspi_pkg::t_in_word            r_in_word;
    logic                           r_out_valid;
    mlspi_pkg::t_out_word           r_out_word;
    logic [mlspi_pkg::DELAY_W-1:0]  r_delay_ticks;
    mlspi_pkg::t_out_word           w_result;
    logic                           w_out_free;
    logic                           w_adv;
    logic                           w_in_take;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    mlspi_seq #(
        .LONG_BITS        (LONG_BITS),
        .SHORT_BITS       (SHORT_BITS),
        .INSTRUCTION_BITS (INSTRUCTION_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_word        (r_in_word),
        .i_delay_ticks (r_delay_ticks),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_delay_ticks <= mlspi_pkg::DELAY_RESET;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_delay_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_word <= i_in_word;
        end
        if (w_adv) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== design/mlspi_seq.sv =====
// ---------------------------------------------------------------------------
// mlspi_seq
// Pin sequencer: holds the write state and advances it by one input word.
// ---------------------------------------------------------------------------
module mlspi_seq #(
    parameter int LONG_BITS        = mlspi_pkg::LONG_BITS_DEF,
    parameter int SHORT_BITS       = mlspi_pkg::SHORT_BITS_DEF,
    parameter int INSTRUCTION_BITS = mlspi_pkg::INSTRUCTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  mlspi_pkg::t_in_word          i_word,
    input  logic [mlspi_pkg::DELAY_W-1:0] i_delay_ticks,
    output mlspi_pkg::t_out_word         o_result
);

    localparam int MAX_A  = (LONG_BITS > SHORT_BITS) ? LONG_BITS : SHORT_BITS;
    localparam int MAX_B  = (MAX_A > INSTRUCTION_BITS) ? MAX_A : INSTRUCTION_BITS;
    localparam int MAX_C  = (MAX_B > mlspi_pkg::GAP_DELAYS) ? MAX_B : mlspi_pkg::GAP_DELAYS;
    localparam int BC_W   = $clog2(MAX_C + 1);
    localparam int MPOS_W = $clog2(mlspi_pkg::MSG_W);
    localparam int IPOS_W = $clog2(mlspi_pkg::INS_W);
    localparam int LN     = mlspi_pkg::LANES;
    localparam int DW     = mlspi_pkg::DELAY_W;

    localparam logic [BC_W-1:0] C_INS_BITS = BC_W'(INSTRUCTION_BITS);
    localparam logic [BC_W-1:0] C_LONG     = BC_W'(LONG_BITS);
    localparam logic [BC_W-1:0] C_SHORT    = BC_W'(SHORT_BITS);
    localparam logic [BC_W-1:0] C_GAP      = BC_W'(mlspi_pkg::GAP_DELAYS);

    mlspi_pkg::t_phase r_phase, n_phase;
    logic [BC_W-1:0]           r_bit_cnt, n_bit_cnt;
    logic [DW-1:0]             r_delay_cnt, n_delay_cnt;
    logic [LN-1:0]             r_mask, n_mask;
    logic                      r_clk, n_clk;
    logic                      r_rst_lvl, n_rst_lvl;
    logic [LN-1:0]             r_data, n_data;
    logic [mlspi_pkg::INS_W-1:0] r_ins;
    logic                      r_long;
    logic [mlspi_pkg::MSG_W-1:0] r_lane [LN];
    logic [mlspi_pkg::MSG_W-1:0] w_lane [LN];
    logic                      n_done;
    logic                      w_load;

    logic [BC_W-1:0]   w_bit_inc;
    logic [BC_W-1:0]   w_bit_dec;
    logic [BC_W-1:0]   w_msg_len;
    logic [BC_W-1:0]   w_ins_pos;
    logic [BC_W-1:0]   w_msg_pos;
    logic              w_ins_bit;
    logic [LN-1:0]     w_ins_data;
    logic [LN-1:0]     w_msg_data;
    logic [DW:0]       w_cnt_inc;
    logic [DW:0]       w_delay_lim;

    assign w_lane[0] = i_word.lane0_message;
    assign w_lane[1] = i_word.lane1_message;
    assign w_lane[2] = i_word.lane2_message;
    assign w_lane[3] = i_word.lane3_message;
    assign w_lane[4] = i_word.lane4_message;
    assign w_lane[5] = i_word.lane5_message;

    assign w_load = i_en && (mlspi_pkg::t_op'(i_word.op) == mlspi_pkg::OP_START)
                    && (r_phase == mlspi_pkg::PH_IDLE);

    assign w_bit_inc = r_bit_cnt + BC_W'(1);
    assign w_bit_dec = r_bit_cnt - BC_W'(1);
    assign w_msg_len = r_long ? C_LONG : C_SHORT;

    assign w_ins_pos = (r_phase == mlspi_pkg::PH_SETUP) ? (C_INS_BITS - BC_W'(1))
                                                       : (C_INS_BITS - BC_W'(2) - r_bit_cnt);
    assign w_ins_bit = (w_ins_pos < BC_W'(mlspi_pkg::INS_W)) ? r_ins[w_ins_pos[IPOS_W-1:0]]
                                                            : 1'b0;
    assign w_ins_data = w_ins_bit ? r_mask : '0;

    assign w_msg_pos = (r_phase == mlspi_pkg::PH_GAP) ? (w_msg_len - BC_W'(1))
                                                     : (r_bit_cnt - BC_W'(2));

    always_comb begin
        for (int i = 0; i < LN; i++) begin
            w_msg_data[i] = r_mask[i] && r_lane[i][MPOS_W'(w_msg_pos)];
        end
    end

    assign w_cnt_inc   = {1'b0, r_delay_cnt} + (DW+1)'(1);
    assign w_delay_lim = (i_delay_ticks == '0) ? (DW+1)'(1) : {1'b0, i_delay_ticks};

    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_delay_cnt = r_delay_cnt;
        n_mask      = r_mask;
        n_clk       = r_clk;
        n_rst_lvl   = r_rst_lvl;
        n_data      = r_data;
        n_done      = 1'b0;
        if (i_en) begin
            case (mlspi_pkg::t_op'(i_word.op))
                mlspi_pkg::OP_TICK: begin
                    if (r_phase != mlspi_pkg::PH_IDLE) begin
                        if (w_cnt_inc >= w_delay_lim) begin
                            n_delay_cnt = '0;
                            case (r_phase)
                                mlspi_pkg::PH_SETUP: begin
                                    n_bit_cnt = '0;
                                    n_data    = w_ins_data;
                                    n_clk     = 1'b0;
                                    n_phase   = mlspi_pkg::PH_INS_LOW;
                                end
                                mlspi_pkg::PH_INS_LOW: begin
                                    n_clk   = 1'b1;
                                    n_phase = mlspi_pkg::PH_INS_HIGH;
                                end
                                mlspi_pkg::PH_INS_HIGH: begin
                                    n_clk = 1'b0;
                                    if (w_bit_inc < C_INS_BITS) begin
                                        n_bit_cnt = w_bit_inc;
                                        n_data    = w_ins_data;
                                        n_phase   = mlspi_pkg::PH_INS_LOW;
                                    end else begin
                                        n_bit_cnt = '0;
                                        n_phase   = mlspi_pkg::PH_GAP;
                                    end
                                end
                                mlspi_pkg::PH_GAP: begin
                                    if (w_bit_inc >= C_GAP) begin
                                        n_bit_cnt = w_msg_len;
                                        n_data    = w_msg_data;
                                        n_clk     = 1'b0;
                                        n_phase   = mlspi_pkg::PH_MSG_LOW;
                                    end else begin
                                        n_bit_cnt = w_bit_inc;
                                    end
                                end
                                mlspi_pkg::PH_MSG_LOW: begin
                                    n_clk   = 1'b1;
                                    n_phase = mlspi_pkg::PH_MSG_HIGH;
                                end
                                mlspi_pkg::PH_MSG_HIGH: begin
                                    n_clk     = 1'b0;
                                    n_bit_cnt = w_bit_dec;
                                    if (w_bit_dec != '0) begin
                                        n_data  = w_msg_data;
                                        n_phase = mlspi_pkg::PH_MSG_LOW;
                                    end else begin
                                        n_phase = mlspi_pkg::PH_TAIL;
                                    end
                                end
                                mlspi_pkg::PH_RST_LOW: begin
                                    n_rst_lvl = 1'b1;
                                    n_phase   = mlspi_pkg::PH_RST_HIGH;
                                end
                                default: begin
                                    n_phase     = mlspi_pkg::PH_IDLE;
                                    n_clk       = 1'b0;
                                    n_rst_lvl   = 1'b0;
                                    n_data      = '0;
                                    n_mask      = '0;
                                    n_bit_cnt   = '0;
                                    n_delay_cnt = '0;
                                    n_done      = 1'b1;
                                end
                            endcase
                        end else begin
                            n_delay_cnt = w_cnt_inc[DW-1:0];
                        end
                    end
                end
                mlspi_pkg::OP_START: begin
                    if (r_phase == mlspi_pkg::PH_IDLE) begin
                        n_mask      = i_word.channel_mask;
                        n_clk       = 1'b0;
                        n_data      = '0;
                        n_bit_cnt   = '0;
                        n_delay_cnt = '0;
                        n_phase     = mlspi_pkg::PH_SETUP;
                    end
                end
                mlspi_pkg::OP_IO_RESET: begin
                    if (r_phase == mlspi_pkg::PH_IDLE) begin
                        n_rst_lvl   = 1'b0;
                        n_delay_cnt = '0;
                        n_phase     = mlspi_pkg::PH_RST_LOW;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_result.serial_clock  = n_clk;
        o_result.chip_select_n = ~n_mask;
        o_result.serial_data   = n_data;
        o_result.io_reset      = n_rst_lvl;
        o_result.busy_res      = (n_phase != mlspi_pkg::PH_IDLE);
        o_result.done_res      = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mlspi_pkg::PH_IDLE;
            r_bit_cnt   <= '0;
            r_delay_cnt <= '0;
            r_mask      <= '0;
            r_clk       <= 1'b0;
            r_rst_lvl   <= 1'b0;
            r_data      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_delay_cnt <= n_delay_cnt;
            r_mask      <= n_mask;
            r_clk       <= n_clk;
            r_rst_lvl   <= n_rst_lvl;
            r_data      <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ins  <= i_word.instruction;
            r_long <= i_word.extended;
            for (int i = 0; i < LN; i++) begin
                r_lane[i] <= w_lane[i];
            end
        end
    end

endmodule

// ===== design/mlspi_chk.sv =====
// ---------------------------------------------------------------------------
// mlspi_chk
// Port-level checks for the multi-lane SPI write master.
// ---------------------------------------------------------------------------
module mlspi_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input mlspi_pkg::t_out_word          o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.busy_res) |->
        ((&o_out_word.chip_select_n) && (o_out_word.serial_data == '0)
         && !o_out_word.serial_clock && !o_out_word.io_reset))
        else $error("pins not idle while not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.done_res) |-> !o_out_word.busy_res)
        else $error("done reported while still busy");

    a_ioreset_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.io_reset) |->
        (o_out_word.busy_res && (&o_out_word.chip_select_n)))
        else $error("io reset strobe with a lane selected");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("pipeline not empty after reset");

endmodule

bind multi_lane_spi_write_master mlspi_chk u_mlspi_chk (.*);
